[src/fsp_pkg.sv]
package fsp_pkg;

    localparam int unsigned SIZE_LIMIT = 3276;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        KIND_DIGIT  = 2'd0,
        KIND_PERIOD = 2'd1,
        KIND_FACE   = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_PERIOD   = 3'd1,
        ST_NOT_NUMERIC = 3'd2,
        ST_BAD_SIZE    = 3'd3,
        ST_EMPTY_FACE  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  char_out;
        kind_t       item_kind;
        status_t     status;
        logic [14:0] size_decipoints;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

[src/fsp_core.sv]
module fsp_core
    import fsp_pkg::*;
#(
    parameter int unsigned SIZE_LIMIT = fsp_pkg::SIZE_LIMIT
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       is_end,
    output push_t      push
);

    logic        after_period_reg, after_period_next;
    logic        bad_digit_seen_reg, bad_digit_seen_next;
    logic [11:0] size_acc_reg, size_acc_next;
    logic        size_overflowed_reg, size_overflowed_next;
    logic        face_started_reg, face_started_next;
    logic        in_blank_run_reg, in_blank_run_next;

    logic [14:0] size_times_ten;
    logic [15:0] size_candidate;
    status_t     end_status;
    result_t     blank_res;

    always_comb begin
        size_times_ten = {size_acc_reg, 3'b000} + {2'b00, size_acc_reg, 1'b0};
        size_candidate = {1'b0, size_times_ten} + {12'd0, char_in[3:0] - CH_ZERO[3:0]};

        if (!after_period_reg) begin
            end_status = ST_NO_PERIOD;
        end else if (bad_digit_seen_reg) begin
            end_status = ST_NOT_NUMERIC;
        end else if (size_acc_reg == 12'd0 || size_overflowed_reg) begin
            end_status = ST_BAD_SIZE;
        end else if (!face_started_reg) begin
            end_status = ST_EMPTY_FACE;
        end else begin
            end_status = ST_OK;
        end

        blank_res = '{char_out: CH_BLANK, item_kind: KIND_FACE, status: ST_OK,
                      size_decipoints: 15'd0, last: 1'b0};
    end

    always_comb begin
        after_period_next    = after_period_reg;
        bad_digit_seen_next  = bad_digit_seen_reg;
        size_acc_next        = size_acc_reg;
        size_overflowed_next = size_overflowed_reg;
        face_started_next    = face_started_reg;
        in_blank_run_next    = in_blank_run_reg;
        push.count  = 2'd0;
        push.first  = '{char_out: char_in, item_kind: KIND_FACE, status: ST_OK,
                        size_decipoints: 15'd0, last: 1'b1};
        push.second = push.first;

        if (is_end) begin
            push.count = 2'd1;
            push.first.char_out  = 8'd0;
            push.first.item_kind = KIND_STATUS;
            push.first.status    = end_status;
            if (end_status == ST_OK || end_status == ST_EMPTY_FACE) begin
                push.first.size_decipoints = size_times_ten;
            end
            after_period_next    = 1'b0;
            bad_digit_seen_next  = 1'b0;
            size_acc_next        = 12'd0;
            size_overflowed_next = 1'b0;
            face_started_next    = 1'b0;
            in_blank_run_next    = 1'b0;
        end else if (!after_period_reg) begin
            if (char_in == CH_PERIOD) begin
                after_period_next    = 1'b1;
                push.count           = 2'd1;
                push.first.item_kind = KIND_PERIOD;
            end else if (char_in == CH_BLANK) begin
                push.count = 2'd0;
            end else if (char_in >= CH_ZERO && char_in <= CH_NINE) begin
                push.count           = 2'd1;
                push.first.item_kind = KIND_DIGIT;
                if (size_candidate > 16'(SIZE_LIMIT)) begin
                    size_acc_next        = 12'(SIZE_LIMIT);
                    size_overflowed_next = 1'b1;
                end else begin
                    size_acc_next = size_candidate[11:0];
                end
            end else begin
                bad_digit_seen_next = 1'b1;
            end
        end else if (char_in == CH_BLANK) begin
            if (face_started_reg) begin
                in_blank_run_next = 1'b1;
            end
        end else begin
            face_started_next = 1'b1;
            if (in_blank_run_reg) begin
                in_blank_run_next = 1'b0;
                push.count  = 2'd2;
                push.second = push.first;
                push.first  = blank_res;
            end else begin
                push.count = 2'd1;
            end
        end

        if (!accept) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_period_reg    <= 1'b0;
            bad_digit_seen_reg  <= 1'b0;
            size_acc_reg        <= 12'd0;
            size_overflowed_reg <= 1'b0;
            face_started_reg    <= 1'b0;
            in_blank_run_reg    <= 1'b0;
        end else if (accept) begin
            after_period_reg    <= after_period_next;
            bad_digit_seen_reg  <= bad_digit_seen_next;
            size_acc_reg        <= size_acc_next;
            size_overflowed_reg <= size_overflowed_next;
            face_started_reg    <= face_started_next;
            in_blank_run_reg    <= in_blank_run_next;
        end
    end

endmodule

[src/fsp_out_queue.sv]
module fsp_out_queue
    import fsp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0]    rptr_reg, rptr_next;
    logic [QUEUE_AW:0]      count_reg, count_next;
    logic                   pop;

    always_comb begin
        has_room   = count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);
        out_valid  = count_reg != '0;
        out_res    = mem[rptr_reg];
        pop        = out_valid && out_ready;
        wptr_next  = wptr_reg + QUEUE_AW'(push.count);
        rptr_next  = rptr_reg + QUEUE_AW'(pop);
        count_next = count_reg + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wptr_reg + QUEUE_AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[src/font_spec_parser.sv]
// Streaming parser for a "size.face" font specification. Send one character per
// transaction on s_ (s_is_end high ends the specification); results come out on m_
// as echoed digits, the period, normalized face characters and one final status
// carrying the size in decipoints. Echoed results are tentative until the status
// says ok. An input transaction is taken every cycle while the four-entry result
// queue has room for two results, and its results are queued and offered on m_ in
// order. A blank run followed by a face character yields two results, but every
// such character follows a blank that yields none, so with m_ready held high the
// queue never holds more than two results and the input is never stalled; the
// input waits only while m_ready is held low and the queue fills past two results.
module font_spec_parser
    import fsp_pkg::*;
#(
    parameter int unsigned SIZE_LIMIT = fsp_pkg::SIZE_LIMIT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_is_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic [1:0]  m_item_kind,
    output logic [2:0]  m_status,
    output logic [14:0] m_size_decipoints,
    output logic        m_last
);

    push_t   push;
    result_t out_res;
    logic    accept;

    assign accept = s_valid && s_ready;

    fsp_core #(
        .SIZE_LIMIT (SIZE_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .char_in (s_char_in),
        .is_end  (s_is_end),
        .push    (push)
    );

    fsp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .has_room  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_char_out        = out_res.char_out;
    assign m_item_kind       = out_res.item_kind;
    assign m_status          = out_res.status;
    assign m_size_decipoints = out_res.size_decipoints;
    assign m_last            = out_res.last;

endmodule
